/* design/cmm_pkg.sv */
package cmm_pkg;

  localparam int SEGMENT_COUNT_DEF = 8;
  localparam int PAGE_COUNT        = 4;
  localparam int PAGE_BITS         = 2;
  localparam int OFS_BITS          = 14;
  localparam int MAGIC_LEN         = 12;

  localparam logic [4:0]  CODE_READ  = 5'h0B;
  localparam logic [4:0]  CODE_WRITE = 5'h0D;
  localparam logic [4:0]  CODE_IOWR  = 5'h15;
  localparam logic [7:0]  PORT_BASE  = 8'hFC;
  localparam logic [11:0] MAGIC_HI   = 12'h5F0;

  localparam logic [1:0] MODE_RAM  = 2'd0;
  localparam logic [1:0] MODE_MENU = 2'd2;

  localparam logic [7:0] BYTE_FF = 8'hFF;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_IOWR,
    CMD_FOREIGN
  } cmd_t;

  typedef struct packed {
    logic       action;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [7:0] control_lines;
    logic [7:0] preload_segment;
  } in_item_t;

  typedef struct packed {
    logic       reply_kind;
    logic [7:0] read_data;
    logic       unlocked;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic       reply_kind;
    logic       force_ff;
    logic       unlocked;
  } res_meta_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_req_t;

  function automatic cmd_t decode_cmd(input logic [7:0] ctrl);
    logic [4:0] code;
    cmd_t       cmd;
    code = ~ctrl[4:0];
    case (code)
      CODE_READ:  cmd = CMD_READ;
      CODE_WRITE: cmd = CMD_WRITE;
      CODE_IOWR:  cmd = CMD_IOWR;
      default:    cmd = CMD_FOREIGN;
    endcase
    return cmd;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h4F;
      4'd1:    b = 8'h50;
      4'd2:    b = 8'h45;
      4'd3:    b = 8'h4E;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h54;
      4'd6:    b = 8'h48;
      4'd7:    b = 8'h45;
      4'd8:    b = 8'h20;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h52;
      4'd11:   b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/cmm_store.sv */
module cmm_store #(
  parameter int SEGMENT_COUNT = cmm_pkg::SEGMENT_COUNT_DEF,
  parameter int AW = cmm_pkg::OFS_BITS + $clog2(SEGMENT_COUNT)
) (
  input  logic              clk,
  input  cmm_pkg::mem_req_t req,
  input  logic [AW-1:0]     addr,
  output logic [7:0]        rdata
);

  localparam int DEPTH = SEGMENT_COUNT * (2 ** cmm_pkg::OFS_BITS);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/cmm_ctrl.sv */
module cmm_ctrl #(
  parameter int SEGMENT_COUNT = cmm_pkg::SEGMENT_COUNT_DEF,
  parameter int AW = cmm_pkg::OFS_BITS + $clog2(SEGMENT_COUNT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmm_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_data,
  input  logic               res_ready,
  output cmm_pkg::res_meta_t res,
  output cmm_pkg::mem_req_t  mem_req,
  output logic [AW-1:0]      mem_addr
);

  localparam int SW = $clog2(SEGMENT_COUNT);
  localparam logic [8:0] SEG_LIMIT = 9'(SEGMENT_COUNT);
  localparam logic [3:0] MAGIC_LAST = 4'(cmm_pkg::MAGIC_LEN);

  logic              s1_valid_r, s1_valid_nxt;
  cmm_pkg::in_item_t s1_item_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [7:0]        map_r [cmm_pkg::PAGE_COUNT];
  logic [7:0]        map_nxt [cmm_pkg::PAGE_COUNT];
  logic [3:0]        magic_idx_r, magic_idx_nxt;
  logic              unlocked_r, unlocked_nxt;

  cmm_pkg::cmd_t  cmd;
  logic           ram, menu, produces, fire, accept;
  logic [7:0]     seg;
  logic           seg_ok, pseg_ok, magic_hit;
  logic [AW-1:0]  mapped_addr, flat_addr, preload_addr;

  always_comb begin
    cmd      = cmm_pkg::decode_cmd(s1_item_r.control_lines);
    ram      = (mode_r == cmm_pkg::MODE_RAM);
    menu     = (mode_r == cmm_pkg::MODE_MENU);
    produces = !s1_item_r.action && (cmd == cmm_pkg::CMD_READ || cmd == cmm_pkg::CMD_FOREIGN);
    fire     = s1_valid_r && (!produces || res_ready);
    in_stall = s1_valid_r && !fire;
    accept   = in_valid && !in_stall;

    seg     = map_r[s1_item_r.address[15:14]];
    seg_ok  = ({1'b0, seg} < SEG_LIMIT);
    pseg_ok = ({1'b0, s1_item_r.preload_segment} < SEG_LIMIT);
    mapped_addr  = {seg[SW-1:0], s1_item_r.address[cmm_pkg::OFS_BITS-1:0]};
    preload_addr = {s1_item_r.preload_segment[SW-1:0],
                    s1_item_r.address[cmm_pkg::OFS_BITS-1:0]};
    flat_addr    = AW'(s1_item_r.address);
    magic_hit = (magic_idx_r < MAGIC_LAST) &&
                (s1_item_r.address == {cmm_pkg::MAGIC_HI, magic_idx_r}) &&
                (s1_item_r.write_data == cmm_pkg::magic_byte(magic_idx_r));

    s1_valid_nxt  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    mode_nxt      = mode_r;
    map_nxt       = map_r;
    magic_idx_nxt = magic_idx_r;
    unlocked_nxt  = unlocked_r;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.wdata = s1_item_r.write_data;
    mem_addr      = flat_addr;
    res.valid      = fire && produces;
    res.reply_kind = (cmd != cmm_pkg::CMD_READ);
    res.force_ff   = ram && !seg_ok;
    res.unlocked   = unlocked_r;

    if (fire) begin
      if (s1_item_r.action) begin
        mem_req.we = pseg_ok;
        mem_addr   = preload_addr;
      end else begin
        case (cmd)
          cmm_pkg::CMD_READ: begin
            if (ram) begin
              mem_req.re = seg_ok;
              mem_addr   = mapped_addr;
            end else begin
              mem_req.re = 1'b1;
            end
          end
          cmm_pkg::CMD_WRITE: begin
            if (ram) begin
              mem_req.we = seg_ok;
              mem_addr   = mapped_addr;
            end else if (menu) begin
              if (unlocked_r) begin
                mem_req.we = 1'b1;
              end else if (magic_hit) begin
                magic_idx_nxt = magic_idx_r + 4'd1;
                unlocked_nxt  = (magic_idx_r + 4'd1 == MAGIC_LAST);
              end
            end
          end
          cmm_pkg::CMD_IOWR: begin
            if (ram && s1_item_r.address[7:0] >= cmm_pkg::PORT_BASE) begin
              map_nxt[s1_item_r.address[1:0]] = s1_item_r.write_data;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cfg_valid) begin
      mode_nxt      = cfg_data;
      magic_idx_nxt = '0;
      unlocked_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      mode_r      <= cmm_pkg::MODE_RAM;
      magic_idx_r <= '0;
      unlocked_r  <= 1'b0;
      for (int p = 0; p < cmm_pkg::PAGE_COUNT; p++) begin
        map_r[p] <= 8'(cmm_pkg::PAGE_COUNT - 1 - p);
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      mode_r      <= mode_nxt;
      magic_idx_r <= magic_idx_nxt;
      unlocked_r  <= unlocked_nxt;
      map_r       <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

endmodule

/* design/cartridge_memory_mapper_responder.sv */
// A read or foreign cycle passes the input register, then the store's registered read port
// and the result register side by side, before its result shows. Throughput: one beat per
// cycle while the output is not stalled; a stalled output holds a read or foreign cycle in the input register.
// Reset (rst_n, synchronous): mode RAM, pages 0..3 on segments 3,2,1,0, unlock cleared.
// Store contents are undefined until written; no clearing pass.
module cartridge_memory_mapper_responder #(
  parameter int SEGMENT_COUNT = cmm_pkg::SEGMENT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cmm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);

  localparam int AW = cmm_pkg::OFS_BITS + $clog2(SEGMENT_COUNT);

  cmm_pkg::res_meta_t res;
  cmm_pkg::mem_req_t  mem_req;
  logic [AW-1:0]      mem_addr;
  logic [7:0]         mem_rdata;
  logic               res_ready;
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, force_ff_r, unlocked_r;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || !out_stall;

  cmm_ctrl #(
    .SEGMENT_COUNT(SEGMENT_COUNT),
    .AW(AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .res_ready(res_ready),
    .res      (res),
    .mem_req  (mem_req),
    .mem_addr (mem_addr)
  );

  cmm_store #(
    .SEGMENT_COUNT(SEGMENT_COUNT),
    .AW(AW)
  ) u_store (
    .clk  (clk),
    .req  (mem_req),
    .addr (mem_addr),
    .rdata(mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind_r     <= res.reply_kind;
      force_ff_r <= res.force_ff;
      unlocked_r <= res.unlocked;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item.reply_kind = kind_r;
  assign out_item.read_data  = kind_r ? 8'h00 : (force_ff_r ? cmm_pkg::BYTE_FF : mem_rdata);
  assign out_item.unlocked   = unlocked_r;

endmodule
